// ===== rtl/irdq_pkg.sv =====
// ----------------------------------------------------------------------------
// irdq_pkg
// Shared types and constants for the indexed ring deque.
// ----------------------------------------------------------------------------
package irdq_pkg;

    // Fixed widths of the request and response fields.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 4;
    localparam int VAL_IO_W = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_HIGH = 3'd0,
        KIND_PUSH_LOW  = 3'd1,
        KIND_POP_HIGH  = 3'd2,
        KIND_POP_LOW   = 3'd3,
        KIND_READ      = 3'd4,
        KIND_WRITE     = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Per-request result information handed from the controller to the
    // response register.
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic                 use_mem;
    } rsp_info_t;

endpackage

// ===== rtl/irdq_mem.sv =====
// ----------------------------------------------------------------------------
// irdq_mem
// Single-port slot memory with registered read data, read-before-write.
// ----------------------------------------------------------------------------
module irdq_mem #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [VALUE_BITS-1:0]    wdata,
    output logic [VALUE_BITS-1:0]    rdata
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;

    // An overwrite reads the old contents and stores the new ones in the
    // same cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/irdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// irdq_ctrl
// Head pointer and fill count, request decode, slot address and status.
// ----------------------------------------------------------------------------
module irdq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  irdq_pkg::kind_t             kind,
    input  logic [irdq_pkg::POS_W-1:0]  position,
    output logic                        mem_we,
    output logic [$clog2(DEPTH)-1:0]    mem_addr,
    output irdq_pkg::rsp_info_t         info
);
    import irdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int PW = (FW > POS_W) ? FW : POS_W;
    localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] base;
    logic [FW-1:0] offset;
    logic [SW-1:0] sum;
    logic [CW-1:0] count_ext;
    logic          is_full;
    logic          is_empty;
    logic          in_range;
    logic          we_c;
    logic          use_mem;
    status_t       status;

    assign is_full  = (fill_reg == FW'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign in_range = (PW'(position) < PW'(fill_reg));
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        base      = head_reg;
        offset    = fill_reg;
        we_c      = 1'b0;
        use_mem   = 1'b0;
        status    = ST_OK;
        case (kind)
            KIND_PUSH_HIGH:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    we_c      = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_PUSH_LOW:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    head_next = head_dec;
                    base      = head_dec;
                    offset    = '0;
                    we_c      = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_POP_HIGH:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                    offset    = fill_reg - 1'b1;
                    use_mem   = 1'b1;
                end
            end
            KIND_POP_LOW:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    offset    = '0;
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                    use_mem   = 1'b1;
                end
            end
            KIND_READ, KIND_WRITE:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    offset  = FW'(position);
                    use_mem = 1'b1;
                    we_c    = (kind == KIND_WRITE);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Logical index to slot: the sum stays below twice the depth, so one
    // compare and subtract wraps it.
    assign sum      = SW'(base) + SW'(offset);
    assign mem_addr = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
    assign mem_we   = accept & we_c;

    assign count_ext    = CW'(fill_next);
    assign info.status  = status;
    assign info.count   = count_ext[COUNT_W-1:0];
    assign info.use_mem = use_mem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count exceeds depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer outside store");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status != ST_OK |=> $stable(fill_reg) && $stable(head_reg))
        else $error("refused request changed the deque");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == KIND_PUSH_HIGH || kind == KIND_PUSH_LOW) && !is_full
        |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("push did not grow the fill count");
`endif

endmodule

// ===== rtl/indexed_ring_deque_core.sv =====
// ----------------------------------------------------------------------------
// indexed_ring_deque_core
// Double-ended queue of up to DEPTH values in a circular slot memory.
// ----------------------------------------------------------------------------
// Usage: each request transfer on the req channel (req_valid high, req_stall
// low) carries a kind, a position and a value. It pushes at the high or low
// end, pops from either end, reads entry position, or overwrites entry
// position and returns the old value. Exactly one response transfer follows
// on the rsp channel with the value, the entry count after the request and
// a status (ok, full, empty, index out of range). A refused request leaves
// the deque as it was and returns zero.
// The slot memory is read and written at the edge that accepts the request, and
// the registered read data forms the response in the next cycle. Throughput is
// one request per cycle; the single response register sets that figure, since
// a new request is taken when the response register is empty or its contents
// are transferred in the same cycle.
// When the receiver stalls, the response holds steady and req_stall is
// raised until it is transferred.
// Reset clears the head pointer, the fill count and the response valid; the
// slot memory is not cleared, as every entry is written before it is read.
// ----------------------------------------------------------------------------
module indexed_ring_deque_core #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [irdq_pkg::KIND_W-1:0]     kind,
    input  logic [irdq_pkg::POS_W-1:0]      position,
    input  logic [irdq_pkg::VAL_IO_W-1:0]   value_in,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [irdq_pkg::VAL_IO_W-1:0]   value_out,
    output logic [irdq_pkg::COUNT_W-1:0]    count,
    output logic [irdq_pkg::STATUS_W-1:0]   status
);
    import irdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (VALUE_BITS > VAL_IO_W) ? VALUE_BITS : VAL_IO_W;

    logic                  accept;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic [VALUE_BITS-1:0] wdata;
    logic [XW-1:0]         in_ext;
    logic [XW-1:0]         out_ext;
    rsp_info_t             info;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_info_t             info_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;

    // A new request is taken whenever the response register will be free.
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    // Values are kept to VALUE_BITS bits.
    assign in_ext = XW'(value_in);
    assign wdata  = in_ext[VALUE_BITS-1:0];

    irdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind_t'(kind)),
        .position (position),
        .mem_we   (mem_we),
        .mem_addr (mem_addr),
        .info     (info)
    );

    irdq_mem #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .clk   (clk),
        .en    (accept),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wdata),
        .rdata (mem_rdata)
    );

    // A successful push answers with the pushed value; refusals and no-ops
    // answer with zero. Reads, pops and overwrites take the memory data.
    assign val_next       = (mem_we && !info.use_mem) ? wdata : '0;
    assign rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info;
            val_reg  <= val_next;
        end
    end

    assign out_ext   = info_reg.use_mem ? XW'(mem_rdata) : XW'(val_reg);
    assign value_out = out_ext[VAL_IO_W-1:0];
    assign count     = info_reg.count;
    assign status    = info_reg.status;
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    a_stall_holds_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(value_out)
        && $stable(count) && $stable(status))
        else $error("stalled response changed");

    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> !accept)
        else $error("request taken while response is stalled");

    a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted request produced no response");
`endif

endmodule

// ===== tb/sv/irdq_deque_checker.sv =====
// ----------------------------------------------------------------------------
// irdq_deque_checker
// Watches both channels of the ring deque, predicts every response and
// compares it field by field.
// ----------------------------------------------------------------------------
module irdq_deque_checker
    import irdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      position,
    input  logic [VAL_IO_W-1:0]   value_in,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  logic [VAL_IO_W-1:0]   value_out,
    input  logic [COUNT_W-1:0]    count,
    input  logic [STATUS_W-1:0]   status,
    output int unsigned           mismatches,
    output int unsigned           outstanding,
    output int unsigned           refusals,
    output logic [COUNT_W-1:0]    held_entries
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [VAL_IO_W-1:0] value;
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } deque_rsp_t;

    // One request's effect: its response plus the state update it causes.
    typedef struct packed {
        deque_rsp_t          rsp;
        logic                store_en;
        logic [3:0]          store_slot;
        logic [VAL_IO_W-1:0] store_data;
        logic [3:0]          head_next;
        logic [COUNT_W-1:0]  fill_next;
    } deque_step_t;

    logic [VAL_IO_W-1:0] slot_mem [DEPTH];
    logic [3:0]          head_q;
    logic [COUNT_W-1:0]  fill_q;
    deque_rsp_t          rsp_expect_q [$];

    assign held_entries = fill_q;

    // Slot arithmetic wraps in four bits, which is exactly modulo DEPTH here.
    function automatic deque_step_t deque_apply(kind_t op, logic [POS_W-1:0] pos,
                                                logic [VAL_IO_W-1:0] val);
        deque_step_t st;
        logic [3:0]  slot;
        st = '0;
        st.rsp.status = ST_OK;
        st.head_next = head_q;
        st.fill_next = fill_q;
        case (op)
            KIND_PUSH_HIGH, KIND_PUSH_LOW:
            begin
                if (fill_q == COUNT_W'(DEPTH))
                begin
                    st.rsp.status = ST_FULL;
                end
                else
                begin
                    if (op == KIND_PUSH_HIGH)
                    begin
                        slot = head_q + fill_q[3:0];
                    end
                    else
                    begin
                        slot = head_q - 4'd1;
                        st.head_next = slot;
                    end
                    st.store_en = 1'b1;
                    st.store_slot = slot;
                    st.store_data = val;
                    st.fill_next = fill_q + 1'b1;
                    st.rsp.value = val;
                end
            end
            KIND_POP_HIGH, KIND_POP_LOW:
            begin
                if (fill_q == '0)
                begin
                    st.rsp.status = ST_EMPTY;
                end
                else
                begin
                    st.fill_next = fill_q - 1'b1;
                    if (op == KIND_POP_HIGH)
                    begin
                        slot = head_q + st.fill_next[3:0];
                    end
                    else
                    begin
                        slot = head_q;
                        st.head_next = head_q + 4'd1;
                    end
                    st.rsp.value = slot_mem[slot];
                end
            end
            KIND_READ, KIND_WRITE:
            begin
                if ({1'b0, pos} >= fill_q)
                begin
                    st.rsp.status = ST_RANGE;
                end
                else
                begin
                    slot = head_q + pos;
                    st.rsp.value = slot_mem[slot];
                    if (op == KIND_WRITE)
                    begin
                        st.store_en = 1'b1;
                        st.store_slot = slot;
                        st.store_data = val;
                    end
                end
            end
            default:
            begin
            end
        endcase
        st.rsp.count = st.fill_next;
        return st;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        deque_rsp_t  exp_rsp;
        deque_step_t step;
        int unsigned errs;
        if (!rst_n)
        begin
            head_q <= '0;
            fill_q <= '0;
            mismatches <= 0;
            outstanding <= 0;
            refusals <= 0;
            rsp_expect_q.delete();
        end
        else
        begin
            errs = mismatches;
            // The response side is checked first: the response is registered, so a
            // response never belongs to the request accepted at the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expect_q.size() == 0)
                begin
                    $error("response with no request waiting: value_out %h count %0d status %0d",
                           value_out, count, status);
                    errs++;
                end
                else
                begin
                    exp_rsp = rsp_expect_q.pop_front();
                    if (value_out !== exp_rsp.value)
                    begin
                        $error("value_out: expected %h, got %h", exp_rsp.value, value_out);
                        errs++;
                    end
                    if (count !== exp_rsp.count)
                    begin
                        $error("count: expected %0d, got %0d", exp_rsp.count, count);
                        errs++;
                    end
                    if (status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, status);
                        errs++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                step = deque_apply(kind_t'(kind), position, value_in);
                if (step.store_en)
                begin
                    slot_mem[step.store_slot] <= step.store_data;
                end
                head_q <= step.head_next;
                fill_q <= step.fill_next;
                rsp_expect_q.push_back(step.rsp);
                if (step.rsp.status != ST_OK)
                begin
                    refusals <= refusals + 1;
                end
            end
            mismatches <= errs;
            outstanding <= rsp_expect_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the indexed ring deque core.
// Directed requests cover the empty and full refusals, out-of-range indexes
// and value extremes; then about fourteen hundred random requests steer the
// fill level between empty and full, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import irdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TOTAL     = 1420;
    localparam int QUIET_TAIL       = 150;   // last requests run with no idling
    localparam int HOLD_AT          = 400;   // where the long response hold starts
    localparam int DRAIN_AT         = 800;   // where the sender pauses for a drain
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int LIMIT_CYCLES     = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [KIND_W-1:0]     kind;
    logic [POS_W-1:0]      position;
    logic [VAL_IO_W-1:0]   value_in;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [VAL_IO_W-1:0]   value_out;
    logic [COUNT_W-1:0]    count;
    logic [STATUS_W-1:0]   status;

    int unsigned           mismatches;
    int unsigned           outstanding;
    int unsigned           refusals;
    logic [COUNT_W-1:0]    held_entries;

    // Shared controls between the sender and the receiver processes.
    bit                    idle_on = 1'b1;
    bit                    hold_req = 1'b0;
    bit                    hold_taken = 1'b0;
    int unsigned           cycle_count = 0;
    int unsigned           kind_sent [6];

    indexed_ring_deque_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .position  (position),
        .value_in  (value_in),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value_out (value_out),
        .count     (count),
        .status    (status)
    );

    irdq_deque_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .position     (position),
        .value_in     (value_in),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .value_out    (value_out),
        .count        (count),
        .status       (status),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .refusals     (refusals),
        .held_entries (held_entries)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog. The slowest legal run is far below this limit, so reaching
    // it means the block has hung on one of its handshakes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Response side. Normally it stalls in short random bursts. Once, on
    // request from the sender, it holds stall high for a long stretch so the
    // response register stays occupied and the block has to stall its input.
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Offers one request and returns at the edge where it is transferred.
    // A gap, when taken, lowers valid once in this time step and raises it
    // again only at a later edge, so valid never toggles within one step.
    // While the request waits on stall its payload is held steady.
    task automatic issue(input kind_t op, input logic [POS_W-1:0] pos,
                         input logic [VAL_IO_W-1:0] val);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        kind <= op;
        position <= pos;
        value_in <= val;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        kind_sent[int'(op)]++;
    endtask

    initial
    begin
        int unsigned         mode;
        int unsigned         pick;
        kind_t               op;
        logic [POS_W-1:0]    pos;
        logic [VAL_IO_W-1:0] val;

        rst_n <= 1'b0;
        req_valid <= 1'b0;
        kind <= KIND_PUSH_HIGH;
        position <= '0;
        value_in <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Start empty: both pops are refused, and any index
        // is out of range, including the highest one.
        issue(KIND_POP_HIGH, 4'd0, '0);
        issue(KIND_POP_LOW, 4'd0, '0);
        issue(KIND_READ, 4'd0, 32'hFFFF_FFFF);
        issue(KIND_WRITE, 4'd15, 32'hFFFF_FFFF);

        // Fill to capacity from both ends, so the head pointer wraps below
        // slot zero and the high end wraps past slot fifteen.
        for (int i = 0; i < 16; i++)
        begin
            val = (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
            issue(i[0] ? KIND_PUSH_LOW : KIND_PUSH_HIGH, i[3:0], val);
        end

        // Full: pushes at either end are refused, the top index is valid.
        issue(KIND_PUSH_HIGH, 4'd0, 32'hDEAD_BEEF);
        issue(KIND_PUSH_LOW, 4'd0, 32'h1234_5678);
        issue(KIND_READ, 4'd15, '0);
        issue(KIND_WRITE, 4'd0, 32'h8000_0001);
        issue(KIND_READ, 4'd0, '0);
        issue(KIND_POP_HIGH, 4'd0, '0);
        issue(KIND_POP_LOW, 4'd0, '0);
        // Fourteen entries remain, so index fifteen is now out of range.
        issue(KIND_READ, 4'd15, '0);

        // Random part. Every forty requests a new bias is chosen: mostly
        // pushes, mostly pops, or an even mix. This drives the fill level
        // into both the full and the empty refusals many times over.
        mode = 0;
        for (int n = 0; n < RANDOM_TOTAL; n++)
        begin
            if (n % 40 == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            if (n == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
            if (n == DRAIN_AT)
            begin
                // Pause the sender until every response is back. Valid is
                // lowered in the step of the last transfer, and the check is
                // made at the falling edge, after the checker has updated.
                req_valid <= 1'b0;
                @(negedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            if (n == RANDOM_TOTAL - QUIET_TAIL)
            begin
                idle_on = 1'b0;
            end

            pick = $urandom_range(0, 99);
            if (mode == 2)
            begin
                op = kind_t'($urandom_range(0, 5));
            end
            else if (pick < 65)
            begin
                if (mode == 0)
                    op = $urandom_range(0, 1) ? KIND_PUSH_LOW : KIND_PUSH_HIGH;
                else
                    op = $urandom_range(0, 1) ? KIND_POP_LOW : KIND_POP_HIGH;
            end
            else if (pick < 80)
            begin
                if (mode == 0)
                    op = $urandom_range(0, 1) ? KIND_POP_LOW : KIND_POP_HIGH;
                else
                    op = $urandom_range(0, 1) ? KIND_PUSH_LOW : KIND_PUSH_HIGH;
            end
            else
            begin
                op = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
            end

            // The fill level seen here may lag one request behind, which
            // only shifts the split between valid and out-of-range indexes.
            if (held_entries != 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(0, int'(held_entries) - 1));
            else
                pos = POS_W'($urandom_range(0, 15));

            case ($urandom_range(0, 9))
                0: val = 32'h0000_0000;
                1: val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase

            issue(op, pos, val);
        end

        // Wind down: stop offering, wait for the last responses, then keep the
        // clock running briefly so any stray response would still be seen.
        req_valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);

        $display("Sent %0d push, %0d pop, %0d read and %0d overwrite requests; %0d refused.",
                 kind_sent[0] + kind_sent[1], kind_sent[2] + kind_sent[3],
                 kind_sent[4], kind_sent[5], refusals);
        $display("Included a %0d-cycle response hold and one full drain pause.",
                 LONG_HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== indexed_ring_deque_core.f =====
rtl/irdq_pkg.sv
rtl/irdq_mem.sv
rtl/irdq_ctrl.sv
rtl/indexed_ring_deque_core.sv
tb/sv/irdq_deque_checker.sv
tb/sv/tb.sv
